// ===== rtl/buddy_page_allocator_defines.svh =====
// assertion macros shared by the buddy page allocator rtl
// no dependencies; users supply clock and reset in scope
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define BPA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define BPA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define BPA_ASSERT(lbl, prop, msg)
`define BPA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/bpa_pkg.sv =====
// types, codes and counter helpers of the buddy page allocator
// no dependencies
package bpa_pkg;

   localparam int NUM_PAGES = 1024;
   localparam int MAX_ORDER = 10;
   localparam int PAGE_W    = 10;
   localparam int CNT_W     = 11;
   localparam int LINK_W    = 11;
   localparam int ORD_W     = 4;

   localparam logic [LINK_W-1:0] NIL_LINK   = LINK_W'(NUM_PAGES);
   localparam logic [ORD_W-1:0]  NOT_LISTED = '1;
   localparam logic [ORD_W-1:0]  MAX_ORD_C  = ORD_W'(MAX_ORDER);
   localparam logic [CNT_W-1:0]  PAGES_C    = CNT_W'(NUM_PAGES);

   localparam logic [1:0] ACT_ALLOC = 2'd0;
   localparam logic [1:0] ACT_FREE  = 2'd1;
   localparam logic [1:0] ACT_INIT  = 2'd2;

   localparam logic [1:0] STS_OK     = 2'd0;
   localparam logic [1:0] STS_OOM    = 2'd1;
   localparam logic [1:0] STS_INV    = 2'd2;
   localparam logic [1:0] STS_DFREE  = 2'd3;

   localparam logic REG_TOTAL = 1'b0;

   typedef struct packed {
      logic              en_used;
      logic              en_lord;
      logic              en_next;
      logic              en_prev;
      logic [PAGE_W-1:0] addr;
      logic              used;
      logic [ORD_W-1:0]  lord;
      logic [LINK_W-1:0] next;
      logic [LINK_W-1:0] prev;
   } bpa_wr_type;

   typedef struct packed {
      logic              used;
      logic [ORD_W-1:0]  lord;
      logic [LINK_W-1:0] next;
      logic [LINK_W-1:0] prev;
   } bpa_ent_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [PAGE_W-1:0] block_page;
      logic [CNT_W-1:0]  free_total;
      logic [CNT_W-1:0]  allocated_total;
   } bpa_res_type;

   function automatic logic [CNT_W-1:0] cnt_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? '1 : s[CNT_W-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] cnt_sub(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
      return (a > b) ? a - b : '0;
   endfunction

endpackage

// ===== rtl/buddy_page_allocator.sv =====
// channel        | direction | handshake                | payload
// req_           | in        | req_valid / req_stall    | action, order, page
// rsp_           | out       | rsp_valid / rsp_stall    | status, block_page, free/allocated totals
// csr_           | in        | apb write/read, pready=1 | total_pages @0, reserved_pages @4
//
// after reset a sweep over all 1024 pages clears the page memory; requests stall until it ends
// alloc: unlink the list head, split down to the requested order, then mark each page used;
// free: check each page, clear each page, then merge with free buddies and push the block;
// double free: stops once the pages are checked; init: the sweep, then a push per block laid down;
// all steps share the single write port of the page memory, one entry per cycle
// a result waits in the output register while the next request is taken
// top level: configuration registers, allocator engine and result register
// depends on bpa_pkg, bpa_csr, bpa_engine
module buddy_page_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [3:0]  req_order,
   input  logic [9:0]  req_page,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [9:0]  rsp_block_page,
   output logic [10:0] rsp_free_total,
   output logic [10:0] rsp_allocated_total,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bpa_pkg::*;

   logic [CNT_W-1:0] total_pages;
   logic [CNT_W-1:0] reserved_pages;
   logic             in_ready;
   logic             done;
   logic             load;
   bpa_res_type      res;
   bpa_res_type      rsp_ff;
   logic             rsp_valid_ff, rsp_valid_in;

   bpa_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .total_pages    (total_pages),
      .reserved_pages (reserved_pages)
   );

   bpa_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (in_ready),
      .in_action    (req_action),
      .in_order     (req_order),
      .in_page      (req_page),
      .cfg_total    (total_pages),
      .cfg_reserved (reserved_pages),
      .done         (done),
      .res          (res),
      .done_take    (load)
   );

   // result register frees up once its beat is taken
   assign load         = done & (~rsp_valid_ff | ~rsp_stall);
   assign rsp_valid_in = load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= res;
      end
   end

   assign req_stall           = ~in_ready;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_block_page      = rsp_ff.block_page;
   assign rsp_free_total      = rsp_ff.free_total;
   assign rsp_allocated_total = rsp_ff.allocated_total;

endmodule

// ===== rtl/bpa_csr.sv =====
// configuration registers of the buddy page allocator, apb style access
// depends on bpa_pkg
module bpa_csr (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [2:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready,
   output logic [bpa_pkg::CNT_W-1:0] total_pages,
   output logic [bpa_pkg::CNT_W-1:0] reserved_pages
);
   import bpa_pkg::*;

   logic [CNT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] resv_ff, resv_in;
   logic             wr_en;

   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      total_in = total_ff;
      resv_in  = resv_ff;
      if (wr_en) begin
         if (csr_paddr[2] == REG_TOTAL) begin
            total_in = csr_pwdata[CNT_W-1:0];
         end else begin
            resv_in = csr_pwdata[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= CNT_W'(1024);
         resv_ff  <= CNT_W'(1);
      end else begin
         total_ff <= total_in;
         resv_ff  <= resv_in;
      end
   end

   assign csr_prdata     = (csr_paddr[2] == REG_TOTAL) ? 32'(total_ff) : 32'(resv_ff);
   assign total_pages    = total_ff;
   assign reserved_pages = resv_ff;

endmodule

// ===== rtl/bpa_engine.sv =====
// allocator sequencer: page memory, free list heads, counters and the step machine
// depends on bpa_pkg and buddy_page_allocator_defines.svh
`include "buddy_page_allocator_defines.svh"
module bpa_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [1:0]                in_action,
   input  logic [bpa_pkg::ORD_W-1:0]  in_order,
   input  logic [bpa_pkg::PAGE_W-1:0] in_page,
   input  logic [bpa_pkg::CNT_W-1:0]  cfg_total,
   input  logic [bpa_pkg::CNT_W-1:0]  cfg_reserved,
   output logic                      done,
   output bpa_pkg::bpa_res_type      res,
   input  logic                      done_take
);
   import bpa_pkg::*;

   localparam logic [3:0] ST_CLEAR    = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_A_UNLINK = 4'd2;
   localparam logic [3:0] ST_A_SPLIT  = 4'd3;
   localparam logic [3:0] ST_MARK     = 4'd4;
   localparam logic [3:0] ST_F_CHK    = 4'd5;
   localparam logic [3:0] ST_F_CLR    = 4'd6;
   localparam logic [3:0] ST_F_MRG    = 4'd7;
   localparam logic [3:0] ST_F_BUD    = 4'd8;
   localparam logic [3:0] ST_F_UNP    = 4'd9;
   localparam logic [3:0] ST_F_UNN    = 4'd10;
   localparam logic [3:0] ST_PUSH     = 4'd11;
   localparam logic [3:0] ST_PUSH2    = 4'd12;
   localparam logic [3:0] ST_INIT_BLK = 4'd13;
   localparam logic [3:0] ST_DONE     = 4'd14;

   localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(NUM_PAGES - 1);

   // page memory, one entry per page
   logic              used_mem [NUM_PAGES];
   logic [ORD_W-1:0]  lord_mem [NUM_PAGES];
   logic [LINK_W-1:0] next_mem [NUM_PAGES];
   logic [LINK_W-1:0] prev_mem [NUM_PAGES];
   bpa_ent_type       rdata_ff;
   bpa_wr_type        wr;
   logic [PAGE_W-1:0] rd_addr;

   logic [3:0]        state_ff, state_in;
   logic [PAGE_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]  cur_ff, cur_in;
   logic [ORD_W-1:0]  k_ff, k_in;
   logic [ORD_W-1:0]  ord_ff, ord_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [PAGE_W-1:0] blk_ff, blk_in;
   logic [LINK_W-1:0] lp_ff, lp_in;
   logic [LINK_W-1:0] ln_ff, ln_in;
   logic [LINK_W-1:0] h_ff, h_in;
   logic              bad_ff, bad_in;
   logic              init_ff, init_in;
   logic [CNT_W-1:0]  tp_ff, tp_in;
   logic [CNT_W-1:0]  rp_ff, rp_in;
   logic [CNT_W-1:0]  free_ff, free_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [1:0]        status_ff, status_in;
   logic [LINK_W-1:0] head_ff [MAX_ORDER+1];
   logic [LINK_W-1:0] head_in [MAX_ORDER+1];

   logic [CNT_W-1:0]  size;
   logic [CNT_W-1:0]  size_req;
   logic [CNT_W-1:0]  bit_k;
   logic [CNT_W-1:0]  tp_calc;
   logic              last_idx;
   logic [ORD_W-1:0]  fk;
   logic              found;
   logic [ORD_W-1:0]  ik;
   logic [ORD_W-1:0]  kk;
   logic [PAGE_W-1:0] bud;
   logic [PAGE_W-1:0] split_addr;
   logic              heads_ok;

   assign size       = CNT_W'(1) << ord_ff;
   assign size_req   = CNT_W'(1) << in_order;
   assign bit_k      = CNT_W'(1) << k_ff;
   assign last_idx   = ({1'b0, idx_ff} == (size - CNT_W'(1)));
   assign kk         = k_ff - ORD_W'(1);
   assign split_addr = blk_ff | (PAGE_W'(1) << kk);
   assign bud        = cur_ff[PAGE_W-1:0] ^ bit_k[PAGE_W-1:0];
   assign tp_calc    = (cfg_total > PAGES_C) ? PAGES_C : cfg_total;

   // smallest non-empty order at or above the request
   always_comb begin
      fk    = '0;
      found = 1'b0;
      for (int j = MAX_ORDER; j >= 0; j--) begin
         if (!head_ff[j][LINK_W-1] && (ORD_W'(j) >= in_order)) begin
            fk    = ORD_W'(j);
            found = 1'b1;
         end
      end
   end

   // largest aligned block at cur that stays inside the region
   always_comb begin
      ik = '0;
      for (int j = 0; j <= MAX_ORDER; j++) begin
         if (((cur_ff & ((CNT_W'(1) << j) - CNT_W'(1))) == '0) &&
             (({1'b0, cur_ff} + ((CNT_W+1)'(1) << j)) <= {1'b0, tp_ff})) begin
            ik = ORD_W'(j);
         end
      end
   end

   always_comb begin
      heads_ok = 1'b1;
      for (int j = 0; j <= MAX_ORDER; j++) begin
         if (head_ff[j][LINK_W-1] && (head_ff[j][LINK_W-2:0] != '0)) begin
            heads_ok = 1'b0;
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      cur_in    = cur_ff;
      k_in      = k_ff;
      ord_in    = ord_ff;
      page_in   = page_ff;
      blk_in    = blk_ff;
      lp_in     = lp_ff;
      ln_in     = ln_ff;
      h_in      = h_ff;
      bad_in    = bad_ff;
      init_in   = init_ff;
      tp_in     = tp_ff;
      rp_in     = rp_ff;
      free_in   = free_ff;
      used_in   = used_ff;
      status_in = status_ff;
      head_in   = head_ff;
      wr        = '0;
      rd_addr   = '0;
      in_ready  = 1'b0;
      done      = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            wr.en_used = 1'b1;
            wr.en_lord = 1'b1;
            wr.addr    = idx_ff;
            wr.used    = ({1'b0, idx_ff} < rp_ff);
            wr.lord    = NOT_LISTED;
            idx_in     = idx_ff + PAGE_W'(1);
            if (idx_ff == LAST_PAGE) begin
               if (init_ff) begin
                  cur_in   = rp_ff;
                  state_in = ST_INIT_BLK;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               ord_in    = in_order;
               page_in   = in_page;
               status_in = STS_OK;
               blk_in    = '0;
               bad_in    = 1'b0;
               idx_in    = '0;
               init_in   = 1'b0;
               state_in  = ST_DONE;
               case (in_action)
                  ACT_INIT: begin
                     tp_in   = tp_calc;
                     rp_in   = (cfg_reserved > tp_calc) ? tp_calc : cfg_reserved;
                     free_in = '0;
                     used_in = '0;
                     init_in = 1'b1;
                     for (int j = 0; j <= MAX_ORDER; j++) begin
                        head_in[j] = NIL_LINK;
                     end
                     state_in = ST_CLEAR;
                  end
                  ACT_ALLOC: begin
                     if (in_order > MAX_ORD_C) begin
                        status_in = STS_INV;
                     end else if (!found) begin
                        status_in = STS_OOM;
                     end else begin
                        k_in     = fk;
                        blk_in   = head_ff[fk][PAGE_W-1:0];
                        rd_addr  = head_ff[fk][PAGE_W-1:0];
                        state_in = ST_A_UNLINK;
                     end
                  end
                  ACT_FREE: begin
                     if ((in_order > MAX_ORD_C) ||
                         ((in_page & (size_req[PAGE_W-1:0] - PAGE_W'(1))) != '0) ||
                         (({1'b0, in_page} + size_req) > PAGES_C)) begin
                        status_in = STS_INV;
                     end else begin
                        rd_addr  = in_page;
                        state_in = ST_F_CHK;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_A_UNLINK: begin
            // taken block is the list head, so only its successor needs a new prev
            head_in[k_ff] = rdata_ff.next;
            if (!rdata_ff.next[LINK_W-1]) begin
               wr.en_prev = 1'b1;
               wr.addr    = rdata_ff.next[PAGE_W-1:0];
               wr.prev    = NIL_LINK;
            end
            idx_in   = '0;
            state_in = (k_ff > ord_ff) ? ST_A_SPLIT : ST_MARK;
         end

         ST_A_SPLIT: begin
            // lists below the taken order are empty, so upper halves go in alone
            wr.en_lord  = 1'b1;
            wr.en_next  = 1'b1;
            wr.en_prev  = 1'b1;
            wr.addr     = split_addr;
            wr.lord     = kk;
            wr.next     = NIL_LINK;
            wr.prev     = NIL_LINK;
            head_in[kk] = {1'b0, split_addr};
            k_in        = kk;
            if (kk == ord_ff) begin
               state_in = ST_MARK;
            end
         end

         ST_MARK: begin
            wr.en_used = 1'b1;
            wr.en_lord = (idx_ff == '0);
            wr.addr    = blk_ff | idx_ff;
            wr.used    = 1'b1;
            wr.lord    = NOT_LISTED;
            idx_in     = idx_ff + PAGE_W'(1);
            if (last_idx) begin
               used_in   = cnt_add(used_ff, size);
               free_in   = cnt_sub(free_ff, size);
               status_in = STS_OK;
               state_in  = ST_DONE;
            end
         end

         ST_F_CHK: begin
            bad_in = bad_ff | !rdata_ff.used;
            if (last_idx) begin
               idx_in = '0;
               if (bad_ff || !rdata_ff.used) begin
                  status_in = STS_DFREE;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_F_CLR;
               end
            end else begin
               idx_in  = idx_ff + PAGE_W'(1);
               rd_addr = page_ff | (idx_ff + PAGE_W'(1));
            end
         end

         ST_F_CLR: begin
            wr.en_used = 1'b1;
            wr.addr    = page_ff | idx_ff;
            wr.used    = 1'b0;
            idx_in     = idx_ff + PAGE_W'(1);
            if (last_idx) begin
               used_in  = cnt_sub(used_ff, size);
               free_in  = cnt_add(free_ff, size);
               cur_in   = {1'b0, page_ff};
               k_in     = ord_ff;
               state_in = ST_F_MRG;
            end
         end

         ST_F_MRG: begin
            if (k_ff == MAX_ORD_C) begin
               state_in = ST_PUSH;
            end else begin
               rd_addr  = bud;
               state_in = ST_F_BUD;
            end
         end

         ST_F_BUD: begin
            // a block listed at this order has all of its pages unused
            if (rdata_ff.lord != k_ff) begin
               state_in = ST_PUSH;
            end else begin
               lp_in      = rdata_ff.prev;
               ln_in      = rdata_ff.next;
               wr.en_lord = 1'b1;
               wr.addr    = bud;
               wr.lord    = NOT_LISTED;
               state_in   = ST_F_UNP;
            end
         end

         ST_F_UNP: begin
            if (!lp_ff[LINK_W-1]) begin
               wr.en_next = 1'b1;
               wr.addr    = lp_ff[PAGE_W-1:0];
               wr.next    = ln_ff;
            end else begin
               head_in[k_ff] = ln_ff;
            end
            state_in = ST_F_UNN;
         end

         ST_F_UNN: begin
            if (!ln_ff[LINK_W-1]) begin
               wr.en_prev = 1'b1;
               wr.addr    = ln_ff[PAGE_W-1:0];
               wr.prev    = lp_ff;
            end
            cur_in   = cur_ff & ~bit_k;
            k_in     = k_ff + ORD_W'(1);
            state_in = ST_F_MRG;
         end

         ST_PUSH: begin
            h_in          = head_ff[k_ff];
            wr.en_lord    = 1'b1;
            wr.en_next    = 1'b1;
            wr.en_prev    = 1'b1;
            wr.addr       = cur_ff[PAGE_W-1:0];
            wr.lord       = k_ff;
            wr.next       = head_ff[k_ff];
            wr.prev       = NIL_LINK;
            head_in[k_ff] = cur_ff;
            state_in      = ST_PUSH2;
         end

         ST_PUSH2: begin
            if (!h_ff[LINK_W-1]) begin
               wr.en_prev = 1'b1;
               wr.addr    = h_ff[PAGE_W-1:0];
               wr.prev    = cur_ff;
            end
            if (init_ff) begin
               free_in  = cnt_add(free_ff, bit_k);
               cur_in   = cur_ff + bit_k;
               state_in = ST_INIT_BLK;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_INIT_BLK: begin
            if (cur_ff < tp_ff) begin
               k_in     = ik;
               state_in = ST_PUSH;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            done = 1'b1;
            if (done_take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr.en_used) used_mem[wr.addr] <= wr.used;
      if (wr.en_lord) lord_mem[wr.addr] <= wr.lord;
      if (wr.en_next) next_mem[wr.addr] <= wr.next;
      if (wr.en_prev) prev_mem[wr.addr] <= wr.prev;
      rdata_ff.used <= used_mem[rd_addr];
      rdata_ff.lord <= lord_mem[rd_addr];
      rdata_ff.next <= next_mem[rd_addr];
      rdata_ff.prev <= prev_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff   <= '0;
         init_ff  <= 1'b0;
         rp_ff    <= '0;
         free_ff  <= '0;
         used_ff  <= '0;
         for (int j = 0; j <= MAX_ORDER; j++) begin
            head_ff[j] <= NIL_LINK;
         end
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         init_ff  <= init_in;
         rp_ff    <= rp_in;
         free_ff  <= free_in;
         used_ff  <= used_in;
         head_ff  <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      k_ff      <= k_in;
      ord_ff    <= ord_in;
      page_ff   <= page_in;
      blk_ff    <= blk_in;
      lp_ff     <= lp_in;
      ln_ff     <= ln_in;
      h_ff      <= h_in;
      bad_ff    <= bad_in;
      tp_ff     <= tp_in;
      status_ff <= status_in;
   end

   assign res.status          = status_ff;
   assign res.block_page      = blk_ff;
   assign res.free_total      = free_ff;
   assign res.allocated_total = used_ff;

   `BPA_ASSERT(a_idle_no_write, (state_ff == ST_IDLE) |-> !(wr.en_used || wr.en_lord || wr.en_next || wr.en_prev), "page memory written while idle")
   `BPA_ASSERT(a_done_holds, (done && !done_take) |=> done, "finished result dropped before it was taken")
   `BPA_ASSERT(a_heads_nil_form, heads_ok, "list head holds an out of range link")
   `BPA_ASSERT(a_push_order, (state_ff == ST_PUSH) |-> (k_ff <= MAX_ORD_C), "block pushed at an order above the maximum")
   `BPA_ASSERT_ALWAYS(a_reset_clear, reset |=> ((state_ff == ST_CLEAR) && (idx_ff == '0)), "reset did not start the clearing sweep")

endmodule

// ===== sim/buddy_page_allocator_tb.sv =====
// testbench for the buddy page allocator: directed and random request beats
// checked against an in-bench model of the free lists, bitmap and counters
// depends on bpa_pkg and buddy_page_allocator
`timescale 1ns / 100ps
`default_nettype none

module buddy_page_allocator_tb;
   import bpa_pkg::*;

   localparam int REG_TOTAL_IDX = 0;
   localparam int REG_RSVD_IDX  = 1;
   localparam int CNT_SAT       = 2047;
   localparam int ORD_NONE      = 15;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam longint CYCLE_LIMIT = 20000000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_action = '0;
   logic [3:0]  req_order = '0;
   logic [9:0]  req_page = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_status;
   logic [9:0]  rsp_block_page;
   logic [10:0] rsp_free_total;
   logic [10:0] rsp_allocated_total;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   buddy_page_allocator dut (.*);

   always #5 clock = ~clock;

   // allocator shadow state
   int unsigned cfg_total, cfg_rsvd;
   bit          used_map [NUM_PAGES];
   int unsigned head_of [MAX_ORDER+1];
   int unsigned nxt [NUM_PAGES];
   int unsigned prv [NUM_PAGES];
   int unsigned lord [NUM_PAGES];
   int unsigned free_pages, alloc_pages;

   bpa_res_type expected_q [$];
   int unsigned rsp_idle_pct, req_idle_pct;
   bit          hold_rsp;
   int          fail_count;
   int          beats_sent, beats_checked;
   longint      cycle_count;
   int unsigned live_blk [$];
   int unsigned live_ord [$];

   function automatic int unsigned sat_add(int unsigned a, int unsigned b);
      return (a + b > CNT_SAT) ? CNT_SAT : a + b;
   endfunction

   function automatic int unsigned sat_sub(int unsigned a, int unsigned b);
      return (a > b) ? a - b : 0;
   endfunction

   function automatic void list_push(int unsigned b, int unsigned k);
      prv[b] = NUM_PAGES;
      nxt[b] = head_of[k];
      if (head_of[k] < NUM_PAGES) prv[head_of[k]] = b;
      head_of[k] = b;
      lord[b] = k;
   endfunction

   function automatic void list_unlink(int unsigned b, int unsigned k);
      if (prv[b] < NUM_PAGES) nxt[prv[b]] = nxt[b];
      else head_of[k] = nxt[b];
      if (nxt[b] < NUM_PAGES) prv[nxt[b]] = prv[b];
      lord[b] = ORD_NONE;
   endfunction

   function automatic void wipe_state();
      for (int i = 0; i < NUM_PAGES; i++) begin
         used_map[i] = 0;
         nxt[i] = 0;
         prv[i] = 0;
         lord[i] = ORD_NONE;
      end
      for (int k = 0; k <= MAX_ORDER; k++) head_of[k] = NUM_PAGES;
      free_pages = 0;
      alloc_pages = 0;
   endfunction

   function automatic void rebuild_region();
      int unsigned tp, rp, cur, k;
      tp = (cfg_total < NUM_PAGES) ? cfg_total : NUM_PAGES;
      rp = (cfg_rsvd < tp) ? cfg_rsvd : tp;
      wipe_state();
      for (int i = 0; i < rp; i++) used_map[i] = 1;
      cur = rp;
      while (cur < tp) begin
         k = MAX_ORDER;
         while (k > 0 && (((cur & ((1 << k) - 1)) != 0) || cur + (1 << k) > tp)) k--;
         list_push(cur, k);
         free_pages = sat_add(free_pages, 1 << k);
         cur += 1 << k;
      end
   endfunction

   function automatic bpa_res_type predict_request(logic [1:0] act, logic [3:0] ord,
                                                   logic [9:0] pg);
      bpa_res_type r;
      int unsigned k, b, sz, cur, bsz, bud;
      bit all_used, bud_ok;
      r = '0;
      r.status = STS_OK;
      if (act == ACT_INIT) begin
         rebuild_region();
      end else if (act == ACT_ALLOC) begin
         if (ord > MAX_ORDER) r.status = STS_INV;
         else begin
            k = ord;
            sz = 1 << ord;
            while (k <= MAX_ORDER && head_of[k] >= NUM_PAGES) k++;
            if (k > MAX_ORDER) r.status = STS_OOM;
            else begin
               b = head_of[k];
               list_unlink(b, k);
               while (k > ord) begin
                  k--;
                  if (b + (1 << k) < NUM_PAGES) list_push(b + (1 << k), k);
               end
               for (int i = 0; i < sz && b + i < NUM_PAGES; i++) used_map[b + i] = 1;
               alloc_pages = sat_add(alloc_pages, sz);
               free_pages = sat_sub(free_pages, sz);
               r.block_page = b[9:0];
               live_blk.push_back(b);
               live_ord.push_back(ord);
            end
         end
      end else if (act == ACT_FREE) begin
         sz = 1 << ((ord <= MAX_ORDER) ? ord : 0);
         if (ord > MAX_ORDER || (pg & (sz - 1)) != 0 || pg + sz > NUM_PAGES)
            r.status = STS_INV;
         else begin
            all_used = 1;
            for (int i = 0; i < sz; i++) if (!used_map[pg + i]) all_used = 0;
            if (!all_used) r.status = STS_DFREE;
            else begin
               for (int i = 0; i < sz; i++) used_map[pg + i] = 0;
               alloc_pages = sat_sub(alloc_pages, sz);
               free_pages = sat_add(free_pages, sz);
               cur = pg;
               k = ord;
               while (k < MAX_ORDER) begin
                  bsz = 1 << k;
                  bud = cur ^ bsz;
                  if (bud + bsz > NUM_PAGES) break;
                  bud_ok = (lord[bud] == k);
                  for (int i = 0; i < bsz && bud_ok; i++) if (used_map[bud + i]) bud_ok = 0;
                  if (!bud_ok) break;
                  list_unlink(bud, k);
                  if (bud < cur) cur = bud;
                  k++;
               end
               list_push(cur, k);
            end
         end
      end
      r.free_total = free_pages[10:0];
      r.allocated_total = alloc_pages[10:0];
      return r;
   endfunction

   // cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("buddy_page_allocator_tb: FAIL");
         $finish;
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset) rsp_stall <= 0;
      else rsp_stall <= hold_rsp || ($urandom_range(99) < rsp_idle_pct);
   end

   // result checker
   always @(posedge clock) begin
      bpa_res_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_checked++;
         if (expected_q.size() == 0) begin
            $error("result beat with nothing expected");
            fail_count++;
         end else begin
            exp_r = expected_q.pop_front();
            if (rsp_status !== exp_r.status) begin
               $error("status exp %0d got %0d", exp_r.status, rsp_status);
               fail_count++;
            end
            if (rsp_block_page !== exp_r.block_page) begin
               $error("block_page exp %0d got %0d", exp_r.block_page, rsp_block_page);
               fail_count++;
            end
            if (rsp_free_total !== exp_r.free_total) begin
               $error("free_total exp %0d got %0d", exp_r.free_total, rsp_free_total);
               fail_count++;
            end
            if (rsp_allocated_total !== exp_r.allocated_total) begin
               $error("allocated_total exp %0d got %0d", exp_r.allocated_total,
                      rsp_allocated_total);
               fail_count++;
            end
         end
      end
   end

   // valid stays up after a beat so the next one can follow directly
   task automatic send_request(logic [1:0] act, logic [3:0] ord, logic [9:0] pg);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_action <= act;
      req_order <= ord;
      req_page <= pg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_q.push_back(predict_request(act, ord, pg));
      beats_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(int idx, int unsigned val);
      drain_results();
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= 3'(4 * idx);
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      if (idx == REG_TOTAL_IDX) cfg_total = val & 'h7FF;
      else cfg_rsvd = val & 'h7FF;
   endtask

   task automatic configure_and_init(int unsigned tp, int unsigned rp);
      csr_write(REG_TOTAL_IDX, tp);
      csr_write(REG_RSVD_IDX, rp);
      send_request(ACT_INIT, 4'($urandom), 10'($urandom));
   endtask

   // pick a free of a live block, sometimes a stale or broken one
   task automatic send_random_free();
      int idx;
      int unsigned r;
      r = $urandom_range(99);
      if (live_blk.size() != 0 && r < 80) begin
         idx = $urandom_range(live_blk.size() - 1);
         send_request(ACT_FREE, 4'(live_ord[idx]), 10'(live_blk[idx]));
         live_blk.delete(idx);
         live_ord.delete(idx);
      end else
         send_request(ACT_FREE, 4'($urandom), 10'($urandom));
   endtask

   task automatic test_directed();
      send_request(ACT_ALLOC, '0, '0);          // alloc before any init
      send_request(ACT_FREE, '0, '0);           // free before init
      send_request(ACT_UNUSED, 4'hF, 10'h3FF);  // unused action code
      configure_and_init(1024, 1);
      send_request(ACT_ALLOC, 4'd11, '0);       // invalid order
      send_request(ACT_ALLOC, 4'hF, 10'h3FF);
      send_request(ACT_ALLOC, '0, '0);
      send_request(ACT_ALLOC, 4'd9, '0);
      send_request(ACT_ALLOC, 4'd10, '0);       // out of memory, no order-10 block
      send_request(ACT_FREE, 4'd1, 10'd1);      // misaligned
      send_request(ACT_FREE, 4'd10, 10'd512);   // beyond region
      send_request(ACT_FREE, 4'hF, '0);
      send_request(ACT_FREE, '0, 10'd1);
      send_request(ACT_FREE, '0, 10'd1);        // double free
      send_request(ACT_FREE, 4'd9, 10'd512);    // buddy holds reserved page 0, no merge
      send_request(ACT_ALLOC, '0, '0);
      send_request(ACT_INIT, '0, '0);           // repeated init
      configure_and_init(1, 0);                 // single page region
      send_request(ACT_ALLOC, '0, '0);
      send_request(ACT_ALLOC, '0, '0);
      configure_and_init(2047, 2047);           // all reserved, values clamp
      send_request(ACT_ALLOC, '0, '0);
      configure_and_init(1000, 0);
      send_request(ACT_ALLOC, 4'd10, '0);
   endtask

   task automatic test_random(int n);
      int unsigned r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 48) send_request(ACT_ALLOC, 4'($urandom_range(r < 40 ? 4 : 15)),
                                  10'($urandom));
         else if (r < 93) send_random_free();
         else if (r < 97) send_request(ACT_INIT, 4'($urandom), 10'($urandom));
         else send_request(ACT_UNUSED, 4'($urandom), 10'($urandom));
      end
   endtask

   task automatic test_backpressure();
      hold_rsp = 1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
         test_random(12);
      join
      drain_results();
   endtask

   initial begin
      cfg_total = 1024;
      cfg_rsvd = 1;
      wipe_state();
      rsp_idle_pct = 0;
      req_idle_pct = 0;
      hold_rsp = 0;
      fail_count = 0;
      cycle_count = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      req_idle_pct = 7;
      rsp_idle_pct = 64;
      configure_and_init($urandom_range(600, 1024), $urandom_range(0, 40));
      test_random(260);
      req_idle_pct = 64;
      rsp_idle_pct = 7;
      configure_and_init($urandom_range(64, 1024), $urandom_range(0, 8));
      test_random(260);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      configure_and_init(1024, 0);
      test_backpressure();
      test_random(260);
      drain_results();
      $display("covered %0d request beats, %0d results: alloc/free/init, split, merge,",
               beats_sent, beats_checked);
      $display("double and invalid frees, out of memory, several region settings");
      if (fail_count == 0) $display("buddy_page_allocator_tb: PASS");
      else $display("buddy_page_allocator_tb: FAIL");
      $finish;
   end
endmodule

`default_nettype wire
